FILE: rtl/ithp_pkg.sv
`default_nettype none

package ithp_pkg;

  // next-header / protocol numbers
  localparam logic [7:0] NhHopByHop = 8'd0;
  localparam logic [7:0] NhIcmp     = 8'd1;
  localparam logic [7:0] NhIgmp     = 8'd2;
  localparam logic [7:0] NhTcp      = 8'd6;
  localparam logic [7:0] NhUdp      = 8'd17;
  localparam logic [7:0] NhRouting  = 8'd43;
  localparam logic [7:0] NhFragment = 8'd44;
  localparam logic [7:0] NhIcmpv6   = 8'd58;
  localparam logic [7:0] NhDestOpts = 8'd60;

  // result protocol codes
  localparam logic [2:0] ProtoUnknown = 3'd0;
  localparam logic [2:0] ProtoTcp     = 3'd1;
  localparam logic [2:0] ProtoUdp     = 3'd2;
  localparam logic [2:0] ProtoIcmp    = 3'd3;
  localparam logic [2:0] ProtoIcmpv6  = 3'd4;
  localparam logic [2:0] ProtoIgmp    = 3'd5;

  // status codes
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusShortHdr  = 2'd1;
  localparam logic [1:0] StatusTruncated = 2'd2;
  localparam logic [1:0] StatusUnderflow = 2'd3;

  // header geometry: last-byte offsets of fixed headers (...Last), byte counts (...Bytes), TCP data-offset byte
  localparam logic [5:0]  Ipv4MinHdrBytes = 6'd20;
  localparam logic [15:0] Ipv6HdrLast     = 16'd39;
  localparam logic [15:0] TcpHdrLast      = 16'd19;
  localparam logic [15:0] UdpHdrLast      = 16'd7;
  localparam logic [15:0] TcpOffsetByte   = 16'd12;
  localparam logic [11:0] FragHdrLast     = 12'd7;
  localparam logic [15:0] UdpHdrBytes     = 16'd8;
  localparam logic [15:0] Icmpv6HdrBytes  = 16'd8;

  // per-packet summary handed from the parser to the back end
  typedef struct packed {
    logic        is_v6;
    logic        short_hdr;
    logic        complete;
    logic [2:0]  proto;
    logic [15:0] ip_len;
    logic [15:0] ext_bytes;
    logic [5:0]  ip_hdr_bytes;
    logic [3:0]  tcp_words;
    logic [15:0] udp_len;
    logic [15:0] source_port;
    logic [15:0] dst_port;
  } rec_t;

  typedef struct packed {
    logic [2:0]  proto_code;
    logic [15:0] source_port;
    logic [15:0] dst_port;
    logic [15:0] l4_len;
    logic        has_ports;
    logic [1:0]  status;
  } res_t;

  function automatic logic [2:0] proto_of(input logic [7:0] nh);
    logic [2:0] code;
    unique case (nh)
      NhTcp:    code = ProtoTcp;
      NhUdp:    code = ProtoUdp;
      NhIcmp:   code = ProtoIcmp;
      NhIcmpv6: code = ProtoIcmpv6;
      NhIgmp:   code = ProtoIgmp;
      default:  code = ProtoUnknown;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ithp_front.sv
`default_nettype none

module ithp_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic         is_ipv6_i,
  input  wire logic         last_byte_i,
  output logic              push_o,
  output ithp_pkg::rec_t    rec_o
);

  typedef enum logic [2:0] {
    PhIpHdr,
    PhExt,
    PhFrag,
    PhTcp,
    PhUdp,
    PhDone,
    PhHalt
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] off_q, off_d;
  logic        v6_q, v6_d;
  logic [5:0]  hdr_bytes_q, hdr_bytes_d;
  logic [15:0] ip_len_q, ip_len_d;
  logic [7:0]  nh_q, nh_d;
  logic [15:0] start_q, start_d;
  logic [15:0] ext_q, ext_d;
  logic [7:0]  ext_len_q, ext_len_d;
  logic [15:0] src_q, src_d;
  logic [15:0] dst_q, dst_d;
  logic [3:0]  tcp_words_q, tcp_words_d;
  logic [15:0] udp_len_q, udp_len_d;
  logic        short_q, short_d;

  logic [15:0] rel;
  logic [16:0] nxt;
  logic [11:0] size_m1;
  logic        enter;

  always_comb begin
    phase_d     = phase_q;
    off_d       = off_q;
    v6_d        = v6_q;
    hdr_bytes_d = hdr_bytes_q;
    ip_len_d    = ip_len_q;
    nh_d        = nh_q;
    start_d     = start_q;
    ext_d       = ext_q;
    ext_len_d   = ext_len_q;
    src_d       = src_q;
    dst_d       = dst_q;
    tcp_words_d = tcp_words_q;
    udp_len_d   = udp_len_q;
    short_d     = short_q;
    enter       = 1'b0;
    rel         = off_q - start_q;
    nxt         = {1'b0, off_q} + 17'd1;
    size_m1     = (phase_q == PhFrag) ? ithp_pkg::FragHdrLast : {1'b0, ext_len_q, 3'b111};

    if (accept_i) begin
      if (off_q == '0) begin
        v6_d = is_ipv6_i;
      end
      if (off_q != 16'hFFFF) begin
        off_d = nxt[15:0];
        unique case (phase_q)
          PhIpHdr: begin
            if (!v6_d) begin
              if (off_q == 16'd0) begin
                hdr_bytes_d = {data_byte_i[3:0], 2'b00};
                if (hdr_bytes_d < ithp_pkg::Ipv4MinHdrBytes) begin
                  short_d = 1'b1;
                  phase_d = PhHalt;
                end
              end else if (off_q == 16'd2) begin
                ip_len_d = {data_byte_i, 8'h00};
              end else if (off_q == 16'd3) begin
                ip_len_d = {ip_len_q[15:8], ip_len_q[7:0] | data_byte_i};
              end else if (off_q == 16'd9) begin
                nh_d = data_byte_i;
              end
              if (phase_d != PhHalt && nxt == {11'd0, hdr_bytes_d}) begin
                start_d = nxt[15:0];
                enter   = 1'b1;
              end
            end else begin
              if (off_q == 16'd4) begin
                ip_len_d = {data_byte_i, 8'h00};
              end else if (off_q == 16'd5) begin
                ip_len_d = {ip_len_q[15:8], ip_len_q[7:0] | data_byte_i};
              end else if (off_q == 16'd6) begin
                nh_d = data_byte_i;
              end
              if (off_q == ithp_pkg::Ipv6HdrLast) begin
                start_d = nxt[15:0];
                enter   = 1'b1;
              end
            end
          end
          PhExt, PhFrag: begin
            if (rel == 16'd0) begin
              nh_d = data_byte_i;
            end else begin
              if (rel == 16'd1 && phase_q == PhExt) begin
                ext_len_d = data_byte_i;
              end
              // header ends when rel reaches size - 1
              if (rel == {4'd0, size_m1}) begin
                ext_d   = ext_q + {4'd0, size_m1} + 16'd1;
                start_d = nxt[15:0];
                enter   = 1'b1;
              end
            end
          end
          PhTcp: begin
            if (rel == 16'd0) begin
              src_d = {data_byte_i, 8'h00};
            end else if (rel == 16'd1) begin
              src_d = {src_q[15:8], src_q[7:0] | data_byte_i};
            end else if (rel == 16'd2) begin
              dst_d = {data_byte_i, 8'h00};
            end else if (rel == 16'd3) begin
              dst_d = {dst_q[15:8], dst_q[7:0] | data_byte_i};
            end else if (rel == ithp_pkg::TcpOffsetByte) begin
              tcp_words_d = data_byte_i[7:4];
            end
            if (rel == ithp_pkg::TcpHdrLast) begin
              phase_d = PhDone;
            end
          end
          PhUdp: begin
            if (rel == 16'd0) begin
              src_d = {data_byte_i, 8'h00};
            end else if (rel == 16'd1) begin
              src_d = {src_q[15:8], src_q[7:0] | data_byte_i};
            end else if (rel == 16'd2) begin
              dst_d = {data_byte_i, 8'h00};
            end else if (rel == 16'd3) begin
              dst_d = {dst_q[15:8], dst_q[7:0] | data_byte_i};
            end else if (rel == 16'd4) begin
              udp_len_d = {data_byte_i, 8'h00};
            end else if (rel == 16'd5) begin
              udp_len_d = {udp_len_q[15:8], udp_len_q[7:0] | data_byte_i};
            end
            if (rel == ithp_pkg::UdpHdrLast) begin
              phase_d = PhDone;
            end
          end
          default: ;
        endcase

        if (enter) begin
          unique case (nh_d)
            ithp_pkg::NhTcp: phase_d = PhTcp;
            ithp_pkg::NhUdp: phase_d = PhUdp;
            ithp_pkg::NhHopByHop, ithp_pkg::NhRouting, ithp_pkg::NhDestOpts: begin
              phase_d   = v6_d ? PhExt : PhDone;
              ext_len_d = '0;
            end
            ithp_pkg::NhFragment: begin
              phase_d   = v6_d ? PhFrag : PhDone;
              ext_len_d = '0;
            end
            default: phase_d = PhDone;
          endcase
        end
      end
    end

    push_o             = accept_i && last_byte_i;
    rec_o.is_v6        = v6_d;
    rec_o.short_hdr    = short_d;
    rec_o.complete     = (phase_d == PhDone);
    rec_o.proto        = ithp_pkg::proto_of(nh_d);
    rec_o.ip_len       = ip_len_d;
    rec_o.ext_bytes    = ext_d;
    rec_o.ip_hdr_bytes = hdr_bytes_d;
    rec_o.tcp_words    = tcp_words_d;
    rec_o.udp_len      = udp_len_d;
    rec_o.source_port  = src_d;
    rec_o.dst_port     = dst_d;

    // packet done: start the next one from a clean slate
    if (push_o) begin
      phase_d     = PhIpHdr;
      off_d       = '0;
      v6_d        = 1'b0;
      hdr_bytes_d = '0;
      ip_len_d    = '0;
      nh_d        = '0;
      start_d     = '0;
      ext_d       = '0;
      ext_len_d   = '0;
      src_d       = '0;
      dst_d       = '0;
      tcp_words_d = '0;
      udp_len_d   = '0;
      short_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIpHdr;
      off_q       <= '0;
      v6_q        <= 1'b0;
      hdr_bytes_q <= '0;
      ip_len_q    <= '0;
      nh_q        <= '0;
      start_q     <= '0;
      ext_q       <= '0;
      ext_len_q   <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      tcp_words_q <= '0;
      udp_len_q   <= '0;
      short_q     <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      off_q       <= off_d;
      v6_q        <= v6_d;
      hdr_bytes_q <= hdr_bytes_d;
      ip_len_q    <= ip_len_d;
      nh_q        <= nh_d;
      start_q     <= start_d;
      ext_q       <= ext_d;
      ext_len_q   <= ext_len_d;
      src_q       <= src_d;
      dst_q       <= dst_d;
      tcp_words_q <= tcp_words_d;
      udp_len_q   <= udp_len_d;
      short_q     <= short_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ithp_queue.sv
`default_nettype none

module ithp_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ithp_pkg::rec_t rec_i,
  input  wire logic           pop_i,
  output ithp_pkg::rec_t      rec_o,
  output logic                valid_o,
  output logic                full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ithp_pkg::rec_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign rec_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ithp_back.sv
`default_nettype none

module ithp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ithp_pkg::rec_t rec_i,
  input  wire logic           rec_valid_i,
  output logic                rec_pop_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output ithp_pkg::res_t      res_o
);

  ithp_pkg::res_t res_q, res_d;
  logic           full_q;
  logic [16:0]    tcp_sub;
  logic [17:0]    diff;
  logic [15:0]    minuend;
  logic [16:0]    subtrahend;
  logic           calc;

  assign empty_o   = !full_q;
  assign res_o     = res_q;
  assign rec_pop_o = rec_valid_i && (!full_q || pop_i);

  always_comb begin
    tcp_sub = (rec_i.is_v6 ? {1'b0, rec_i.ext_bytes} : {11'd0, rec_i.ip_hdr_bytes})
            + {11'd0, rec_i.tcp_words, 2'b00};
    calc       = 1'b1;
    minuend    = rec_i.ip_len;
    subtrahend = tcp_sub;
    priority if (rec_i.proto == ithp_pkg::ProtoTcp) begin
      minuend    = rec_i.ip_len;
      subtrahend = tcp_sub;
    end else if (rec_i.proto == ithp_pkg::ProtoUdp) begin
      minuend    = rec_i.udp_len;
      subtrahend = {1'b0, ithp_pkg::UdpHdrBytes};
    end else if (rec_i.proto == ithp_pkg::ProtoIcmpv6 && rec_i.is_v6) begin
      minuend    = rec_i.ip_len;
      subtrahend = {1'b0, ithp_pkg::Icmpv6HdrBytes};
    end else begin
      calc = 1'b0;
    end
    diff = {2'b00, minuend} - {1'b0, subtrahend};

    res_d = '0;
    priority if (rec_i.short_hdr) begin
      res_d.status = ithp_pkg::StatusShortHdr;
    end else if (!rec_i.complete) begin
      res_d.status = ithp_pkg::StatusTruncated;
    end else begin
      res_d.proto_code = rec_i.proto;
      if (rec_i.proto == ithp_pkg::ProtoTcp || rec_i.proto == ithp_pkg::ProtoUdp) begin
        res_d.source_port = rec_i.source_port;
        res_d.dst_port    = rec_i.dst_port;
        res_d.has_ports   = 1'b1;
      end
      if (calc && diff[17]) begin
        res_d.status = ithp_pkg::StatusUnderflow;
      end else begin
        res_d.status = ithp_pkg::StatusOk;
        if (calc) begin
          res_d.l4_len = diff[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (rec_pop_o) begin
      full_q <= 1'b1;
    end else if (pop_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ip_transport_header_parser.sv
// Accepts one byte per cycle while full is low; full only rises when the summary
// queue between parser and back end is full.
// A packet's summary is queued at the edge that accepts its last byte, then registered
// onto the result ports once the back end's result register is empty or being popped.
// Throughput: one byte per cycle while full is low, one summary per cycle out while pop is held.
// Reset (rst_ni low, asynchronous) clears the parser state and empties the queue and result register.
`default_nettype none

module ip_transport_header_parser #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        is_ipv6_i,
  input  wire logic        last_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       proto_code_o,
  output logic [15:0]      source_port_o,
  output logic [15:0]      dst_port_o,
  output logic [15:0]      l4_len_o,
  output logic             has_ports_o,
  output logic [1:0]       status_o
);

  logic           accept;
  logic           rec_push;
  ithp_pkg::rec_t rec_in, rec_head;
  logic           rec_valid, rec_pop;
  ithp_pkg::res_t res;

  assign accept = push && !full;

  ithp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .is_ipv6_i   (is_ipv6_i),
    .last_byte_i (last_byte_i),
    .push_o      (rec_push),
    .rec_o       (rec_in)
  );

  ithp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .rec_i   (rec_in),
    .pop_i   (rec_pop),
    .rec_o   (rec_head),
    .valid_o (rec_valid),
    .full_o  (full)
  );

  ithp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rec_head),
    .rec_valid_i (rec_valid),
    .rec_pop_o   (rec_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign proto_code_o  = res.proto_code;
  assign source_port_o = res.source_port;
  assign dst_port_o    = res.dst_port;
  assign l4_len_o      = res.l4_len;
  assign has_ports_o   = res.has_ports;
  assign status_o      = res.status;

endmodule

`default_nettype wire
